[design/tpe_pkg.sv]
package tpe_pkg;

	localparam logic [3:0] MODE_NULL    = 4'd0;
	localparam logic [3:0] MODE_BOOL    = 4'd1;
	localparam logic [3:0] MODE_UNS     = 4'd2;
	localparam logic [3:0] MODE_SIGNED  = 4'd3;
	localparam logic [3:0] MODE_REAL    = 4'd4;
	localparam logic [3:0] MODE_ENUM    = 4'd5;
	localparam logic [3:0] MODE_DATE    = 4'd6;
	localparam logic [3:0] MODE_TIME    = 4'd7;
	localparam logic [3:0] MODE_OBJID   = 4'd8;
	localparam logic [3:0] MODE_CTX_UNS = 4'd9;
	localparam logic [3:0] MODE_CTX_BOOL = 4'd10;
	localparam logic [3:0] MODE_OPEN    = 4'd11;
	localparam logic [3:0] MODE_CLOSE   = 4'd12;

	// application tag numbers
	localparam logic [7:0] TAG_NULL   = 8'd0;
	localparam logic [7:0] TAG_BOOL   = 8'd1;
	localparam logic [7:0] TAG_UNS    = 8'd2;
	localparam logic [7:0] TAG_SIGNED = 8'd3;
	localparam logic [7:0] TAG_REAL   = 8'd4;
	localparam logic [7:0] TAG_ENUM   = 8'd9;
	localparam logic [7:0] TAG_DATE   = 8'd10;
	localparam logic [7:0] TAG_TIME   = 8'd11;
	localparam logic [7:0] TAG_OBJID  = 8'd12;

	localparam logic [7:0]  TAG_MAX_NUM  = 8'd254;
	localparam logic [3:0]  TAG_EXT_CODE = 4'd15;
	localparam logic [2:0]  LEN_OPEN     = 3'd6;
	localparam logic [2:0]  LEN_CLOSE    = 3'd7;
	localparam logic [15:0] OID_TYPE_MAX = 16'h03FF;
	localparam logic [31:0] OID_INST_MAX = 32'h003F_FFFF;
	localparam logic [15:0] YEAR_BASE    = 16'd1900;
	localparam logic [15:0] YEAR_ANY     = 16'hFFFF;
	localparam logic [7:0]  FIELD_ANY    = 8'd255;

	localparam int MAX_OCTETS = 6;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [MAX_OCTETS-1:0][7:0] octets;  // octets[0] goes out first
		logic [2:0]                 count;   // 1..6
		logic                       err;
	} tpe_entry_t;

endpackage

[design/tpe_front.sv]
module tpe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [95:0]       in_data,
	output logic              push,
	input  logic              q_full,
	output tpe_pkg::tpe_entry_t entry_s1
);

	logic [3:0]  mode;
	logic [31:0] v;
	logic [15:0] fa;
	logic [7:0]  fb, fc, fd, ctag, room;

	logic        valid_s1;
	logic [7:0]  tagnum;
	logic [3:0]  lowbits;
	logic [2:0]  ccnt;
	logic [31:0] val;
	logic        bad;
	logic [2:0]  len_u, len_s;
	logic        ext;
	logic [2:0]  n;
	logic [31:0] aligned;
	logic [7:0]  year;
	tpe_pkg::tpe_entry_t entry;

	assign mode = in_data[3:0];
	assign v    = in_data[35:4];
	assign fa   = in_data[51:36];
	assign fb   = in_data[59:52];
	assign fc   = in_data[67:60];
	assign fd   = in_data[75:68];
	assign ctag = in_data[83:76];
	assign room = in_data[91:84];

	assign len_u = (v[31:8] == '0) ? 3'd1 : (v[31:16] == '0) ? 3'd2 :
		(v[31:24] == '0) ? 3'd3 : 3'd4;
	// minimal two's complement: the dropped bits are all copies of the sign
	assign len_s = (v[31:7] == '0 || v[31:7] == '1) ? 3'd1 :
		(v[31:15] == '0 || v[31:15] == '1) ? 3'd2 :
		(v[31:23] == '0 || v[31:23] == '1) ? 3'd3 : 3'd4;

	always_comb begin
		tagnum  = tpe_pkg::TAG_NULL;
		lowbits = 4'd0;
		ccnt    = 3'd0;
		val     = v;
		bad     = 1'b0;
		year    = tpe_pkg::FIELD_ANY;
		case (mode)
			tpe_pkg::MODE_NULL: begin
			end
			tpe_pkg::MODE_BOOL: begin
				tagnum  = tpe_pkg::TAG_BOOL;
				lowbits = {3'd0, v != '0};
			end
			tpe_pkg::MODE_UNS: begin
				tagnum  = tpe_pkg::TAG_UNS;
				ccnt    = len_u;
				lowbits = {1'b0, len_u};
			end
			tpe_pkg::MODE_SIGNED: begin
				tagnum  = tpe_pkg::TAG_SIGNED;
				ccnt    = len_s;
				lowbits = {1'b0, len_s};
			end
			tpe_pkg::MODE_REAL: begin
				tagnum  = tpe_pkg::TAG_REAL;
				ccnt    = 3'd4;
				lowbits = 4'd4;
			end
			tpe_pkg::MODE_ENUM: begin
				tagnum  = tpe_pkg::TAG_ENUM;
				ccnt    = len_u;
				lowbits = {1'b0, len_u};
			end
			tpe_pkg::MODE_DATE: begin
				tagnum  = tpe_pkg::TAG_DATE;
				ccnt    = 3'd4;
				lowbits = 4'd4;
				if (fa == tpe_pkg::YEAR_ANY)
					year = tpe_pkg::FIELD_ANY;
				else if (fa >= tpe_pkg::YEAR_BASE &&
						fa <= tpe_pkg::YEAR_BASE + {8'd0, tpe_pkg::TAG_MAX_NUM})
					year = 8'(fa - tpe_pkg::YEAR_BASE);
				else
					bad = 1'b1;
				if (!(fb == tpe_pkg::FIELD_ANY || (fb >= 8'd1 && fb <= 8'd14)) ||
						!(fc == tpe_pkg::FIELD_ANY || (fc >= 8'd1 && fc <= 8'd34)) ||
						!(fd == tpe_pkg::FIELD_ANY || (fd >= 8'd1 && fd <= 8'd7)))
					bad = 1'b1;
				val = {year, fb, fc, fd};
			end
			tpe_pkg::MODE_TIME: begin
				tagnum  = tpe_pkg::TAG_TIME;
				ccnt    = 3'd4;
				lowbits = 4'd4;
				if (!(fa == {8'd0, tpe_pkg::FIELD_ANY} || fa <= 16'd23) ||
						!(fb == tpe_pkg::FIELD_ANY || fb <= 8'd59) ||
						!(fc == tpe_pkg::FIELD_ANY || fc <= 8'd59) ||
						!(fd == tpe_pkg::FIELD_ANY || fd <= 8'd99))
					bad = 1'b1;
				val = {fa[7:0], fb, fc, fd};
			end
			tpe_pkg::MODE_OBJID: begin
				tagnum  = tpe_pkg::TAG_OBJID;
				ccnt    = 3'd4;
				lowbits = 4'd4;
				if (fa > tpe_pkg::OID_TYPE_MAX || v > tpe_pkg::OID_INST_MAX)
					bad = 1'b1;
				val = {fa[9:0], v[21:0]};
			end
			tpe_pkg::MODE_CTX_UNS: begin
				tagnum  = ctag;
				ccnt    = len_u;
				lowbits = {1'b1, len_u};
			end
			tpe_pkg::MODE_CTX_BOOL: begin
				tagnum  = ctag;
				ccnt    = 3'd1;
				lowbits = 4'b1001;
				val     = {31'd0, v != '0};
			end
			tpe_pkg::MODE_OPEN: begin
				tagnum  = ctag;
				lowbits = {1'b1, tpe_pkg::LEN_OPEN};
			end
			tpe_pkg::MODE_CLOSE: begin
				tagnum  = ctag;
				lowbits = {1'b1, tpe_pkg::LEN_CLOSE};
			end
			default: bad = 1'b1;
		endcase
		// context tag 255 is reserved
		if (mode >= tpe_pkg::MODE_CTX_UNS && mode <= tpe_pkg::MODE_CLOSE &&
				ctag > tpe_pkg::TAG_MAX_NUM)
			bad = 1'b1;
	end

	assign ext = tagnum >= {4'd0, tpe_pkg::TAG_EXT_CODE};
	assign n   = 3'd1 + {2'd0, ext} + ccnt;

	// left-justify the content so octet i is always at the same bits
	always_comb begin
		case (ccnt)
			3'd1:    aligned = val << 24;
			3'd2:    aligned = val << 16;
			3'd3:    aligned = val << 8;
			3'd4:    aligned = val;
			default: aligned = '0;
		endcase
	end

	always_comb begin
		int j;
		entry.count = n;
		entry.err   = 1'b0;
		for (int k = 0; k < tpe_pkg::MAX_OCTETS; k++) begin
			j = k - 1 - int'(ext);
			if (k == 0)
				entry.octets[k] = ext ? {tpe_pkg::TAG_EXT_CODE, lowbits} :
					{tagnum[3:0], lowbits};
			else if (ext && k == 1)
				entry.octets[k] = tagnum;
			else if (j >= 0 && j < int'(ccnt))
				entry.octets[k] = aligned[31 - 8*j -: 8];
			else
				entry.octets[k] = 8'd0;
		end
		if (bad || {5'd0, n} > room) begin
			entry.octets = '0;
			entry.count  = 3'd1;
			entry.err    = 1'b1;
		end
	end

	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			entry_s1 <= entry;
		end
	end

endmodule

[design/tpe_queue.sv]
module tpe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tpe_pkg::tpe_entry_t wr_entry,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output tpe_pkg::tpe_entry_t head
);

	tpe_pkg::tpe_entry_t mem_q [tpe_pkg::QUEUE_DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'(tpe_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != 2'd0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

[design/tpe_back.sv]
module tpe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  tpe_pkg::tpe_entry_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_octet,
	output logic              out_last,
	output logic              out_err
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] octet_q;
	logic       last_q, err_q;
	logic       load;
	logic       is_last;

	assign load    = !valid_q || out_ready;
	assign is_last = idx_q == head.count - 3'd1;
	assign pop     = load && head_valid && is_last;

	assign out_valid = valid_q;
	assign out_octet = octet_q;
	assign out_last  = last_q;
	assign out_err   = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= head_valid;
			if (head_valid)
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			octet_q <= head.octets[idx_q];
			last_q  <= is_last;
			err_q   <= head.err;
		end
	end

	// an error request is a single zero octet
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && err_q |-> last_q && octet_q == 8'd0)
		else $error("error result not a lone zero octet");

	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q < head.count)
		else $error("octet index beyond request length");

	// mid-request the head entry must stay in the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd0 |-> head_valid)
		else $error("queue emptied mid-request");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 3'd0)
		else $error("index not rewound after last octet");

endmodule

[design/tagged_primitive_encoder_top.sv]
// Path: the first octet of a request passes the front stage register, the queue and the
// output octet register. The output gives one octet per cycle while m_tready is high; a request
// of n octets (1 to 6, error results 1) leaves the octet serialiser one octet at a time.
// A two-entry queue lets the input run ahead of a stalled output.
// Reset (arst_n, asynchronous, active low) clears all valid flags and queue pointers.
module tagged_primitive_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[3:0], value_bits[35:4], field_a[51:36], field_b[59:52],
	// field_c[67:60], field_d[75:68], context_tag[83:76], room[91:84]
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // octet[7:0]
	output logic        m_tlast,
	output logic        m_tuser   // error
);

	logic                push, q_full, pop, head_valid;
	tpe_pkg::tpe_entry_t entry_s1, head;

	tpe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata),
		.push     (push),
		.q_full   (q_full),
		.entry_s1 (entry_s1)
	);

	tpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_entry   (entry_s1),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tpe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_octet  (m_tdata),
		.out_last   (m_tlast),
		.out_err    (m_tuser)
	);

endmodule

[verif/tagged_primitive_encoder_top_tb.sv]
`timescale 1ns / 100ps

module tagged_primitive_encoder_top_tb;

	localparam logic [7:0] CTX_CLASS_BIT = 8'h08;
	localparam int GAP_PCT = 36;

	typedef struct {
		logic [3:0]  mode;
		logic [31:0] value;
		logic [15:0] fa;
		logic [7:0]  fb;
		logic [7:0]  fc;
		logic [7:0]  fd;
		logic [7:0]  ctag;
		logic [7:0]  room;
	} enc_request_t;

	typedef struct {
		logic [7:0] octet;
		logic       last;
		logic       err;
	} enc_octet_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	enc_octet_t expected_octets[$];
	bit  gaps_on;
	bit  stalls_on;
	int  hold_cycles_left;
	int  fail_count;
	int  requests_sent;
	int  octets_checked;
	int  error_results;

	tagged_primitive_encoder_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned_octets(logic [31:0] v);
		if (v <= 32'hFF) return 1;
		if (v <= 32'hFFFF) return 2;
		if (v <= 32'hFF_FFFF) return 3;
		return 4;
	endfunction

	// shortest two's complement form: bias the value and see if it fits
	function automatic int signed_octets(logic [31:0] v);
		logic [31:0] t;
		t = v + 32'h80;
		if (t <= 32'hFF) return 1;
		t = v + 32'h8000;
		if (t <= 32'hFFFF) return 2;
		t = v + 32'h80_0000;
		if (t <= 32'hFF_FFFF) return 3;
		return 4;
	endfunction

	function automatic bit field_valid(logic [15:0] v, int lo, int hi);
		return (v == 16'(tpe_pkg::FIELD_ANY)) || (v >= lo && v <= hi);
	endfunction

	// works out the tagged octets for one request and queues them
	function automatic void predict_encoding(enc_request_t r);
		logic [7:0]  oct[6];
		logic [7:0]  tagn;
		logic [7:0]  hdr;
		logic [7:0]  yr;
		logic [31:0] payload;
		logic [2:0]  lvt;
		int          n;
		int          plen;
		int          pos;
		bit          ok;
		bit          ctx;
		bit          mark;
		enc_octet_t  e;

		ok = 1'b1;
		ctx = 1'b0;
		mark = 1'b0;
		n = 0;
		plen = -1;
		tagn = 8'd0;
		payload = 32'd0;
		lvt = tpe_pkg::LEN_OPEN;
		yr = 8'd0;
		foreach (oct[i]) oct[i] = 8'd0;

		if (r.mode >= tpe_pkg::MODE_CTX_UNS && r.mode <= tpe_pkg::MODE_CLOSE &&
		    r.ctag > tpe_pkg::TAG_MAX_NUM)
			ok = 1'b0;

		case (r.mode)
			tpe_pkg::MODE_NULL: begin
				tagn = tpe_pkg::TAG_NULL;
				plen = 0;
			end
			tpe_pkg::MODE_BOOL: begin
				oct[0] = {tpe_pkg::TAG_BOOL[3:0], 3'b000, r.value != 32'd0};
				n = 1;
			end
			tpe_pkg::MODE_UNS: begin
				tagn = tpe_pkg::TAG_UNS;
				payload = r.value;
				plen = unsigned_octets(r.value);
			end
			tpe_pkg::MODE_SIGNED: begin
				tagn = tpe_pkg::TAG_SIGNED;
				payload = r.value;
				plen = signed_octets(r.value);
			end
			tpe_pkg::MODE_REAL: begin
				tagn = tpe_pkg::TAG_REAL;
				payload = r.value;
				plen = 4;
			end
			tpe_pkg::MODE_ENUM: begin
				tagn = tpe_pkg::TAG_ENUM;
				payload = r.value;
				plen = unsigned_octets(r.value);
			end
			tpe_pkg::MODE_DATE: begin
				if (r.fa == tpe_pkg::YEAR_ANY)
					yr = 8'd255;
				else if (r.fa >= tpe_pkg::YEAR_BASE &&
				         r.fa <= tpe_pkg::YEAR_BASE + 16'(tpe_pkg::TAG_MAX_NUM))
					yr = 8'(r.fa - tpe_pkg::YEAR_BASE);
				else
					ok = 1'b0;
				if (!field_valid(16'(r.fb), 1, 14) || !field_valid(16'(r.fc), 1, 34) ||
				    !field_valid(16'(r.fd), 1, 7))
					ok = 1'b0;
				tagn = tpe_pkg::TAG_DATE;
				payload = {yr, r.fb, r.fc, r.fd};
				plen = 4;
			end
			tpe_pkg::MODE_TIME: begin
				if (!field_valid(r.fa, 0, 23) || !field_valid(16'(r.fb), 0, 59) ||
				    !field_valid(16'(r.fc), 0, 59) || !field_valid(16'(r.fd), 0, 99))
					ok = 1'b0;
				tagn = tpe_pkg::TAG_TIME;
				payload = {r.fa[7:0], r.fb, r.fc, r.fd};
				plen = 4;
			end
			tpe_pkg::MODE_OBJID: begin
				if (r.fa > tpe_pkg::OID_TYPE_MAX || r.value > tpe_pkg::OID_INST_MAX)
					ok = 1'b0;
				tagn = tpe_pkg::TAG_OBJID;
				payload = {r.fa[9:0], r.value[21:0]};
				plen = 4;
			end
			tpe_pkg::MODE_CTX_UNS: begin
				ctx = 1'b1;
				tagn = r.ctag;
				payload = r.value;
				plen = unsigned_octets(r.value);
			end
			tpe_pkg::MODE_CTX_BOOL: begin
				ctx = 1'b1;
				tagn = r.ctag;
				payload = {31'd0, r.value != 32'd0};
				plen = 1;
			end
			tpe_pkg::MODE_OPEN: mark = 1'b1;
			tpe_pkg::MODE_CLOSE: begin
				mark = 1'b1;
				lvt = tpe_pkg::LEN_CLOSE;
			end
			default: ok = 1'b0;
		endcase

		if (ok && mark) begin
			if (r.ctag < 8'(tpe_pkg::TAG_EXT_CODE)) begin
				oct[0] = {r.ctag[3:0], 1'b1, lvt};
				n = 1;
			end else begin
				oct[0] = {tpe_pkg::TAG_EXT_CODE, 1'b1, lvt};
				oct[1] = r.ctag;
				n = 2;
			end
		end else if (ok && plen >= 0) begin
			hdr = ctx ? CTX_CLASS_BIT : 8'd0;
			pos = 1;
			if (tagn >= 8'(tpe_pkg::TAG_EXT_CODE)) begin
				hdr = hdr | {tpe_pkg::TAG_EXT_CODE, 4'b0000};
				oct[1] = tagn;
				pos = 2;
			end else begin
				hdr = hdr | {tagn[3:0], 4'b0000};
			end
			oct[0] = hdr | 8'(plen);
			for (int i = 0; i < plen; i++)
				oct[pos + i] = 8'(payload >> (8 * (plen - 1 - i)));
			n = pos + plen;
		end

		if (!ok || n == 0 || n > r.room) begin
			e.octet = 8'd0;
			e.last = 1'b1;
			e.err = 1'b1;
			expected_octets.push_back(e);
		end else begin
			for (int i = 0; i < n; i++) begin
				e.octet = oct[i];
				e.last = (i == n - 1);
				e.err = 1'b0;
				expected_octets.push_back(e);
			end
		end
	endfunction

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send_request(input logic [3:0] mode, input logic [31:0] value,
	                            input logic [15:0] fa, input logic [7:0] fb,
	                            input logic [7:0] fc, input logic [7:0] fd,
	                            input logic [7:0] ctag, input logic [7:0] room);
		enc_request_t r;
		r = '{mode, value, fa, fb, fc, fd, ctag, room};
		while (gaps_on && $urandom_range(0, 99) < GAP_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, room, ctag, fd, fc, fb, fa, value, mode};
		do @(negedge clk); while (s_tready !== 1'b1);
		@(posedge clk);
		predict_encoding(r);
		requests_sent++;
	endtask

	task automatic wait_drained();
		while (expected_octets.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_field(int lo, int hi);
		return ($urandom_range(0, 7) == 0) ? tpe_pkg::FIELD_ANY
		                                   : 8'($urandom_range(lo, hi));
	endfunction

	task automatic test_integer_lengths();
		send_request(tpe_pkg::MODE_UNS, 32'h0000_0000, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd255, 8'd255);
		send_request(tpe_pkg::MODE_UNS, 32'h0000_0100, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_UNS, 32'hFFFF_FFFF, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd5);
		send_request(tpe_pkg::MODE_SIGNED, 32'hFFFF_FF80, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_SIGNED, 32'hFFFF_FF7F, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_SIGNED, 32'h0080_0000, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_SIGNED, 32'h8000_0000, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_ENUM, 32'h0100_0000, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
	endtask

	task automatic test_fixed_modes();
		send_request(tpe_pkg::MODE_NULL, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF,
		             8'hFF, 8'd1);
		send_request(tpe_pkg::MODE_BOOL, 32'h8000_0000, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_REAL, 32'hFFFF_FFFF, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd5);
		send_request(tpe_pkg::MODE_DATE, 32'd0, tpe_pkg::YEAR_ANY, tpe_pkg::FIELD_ANY,
		             tpe_pkg::FIELD_ANY, tpe_pkg::FIELD_ANY, 8'd0, 8'd255);
		send_request(tpe_pkg::MODE_DATE, 32'd0, 16'd2154, 8'd14, 8'd34, 8'd7,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_TIME, 32'd0, 16'd23, 8'd59, 8'd59, 8'd99,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_TIME, 32'd0, 16'd255, tpe_pkg::FIELD_ANY,
		             tpe_pkg::FIELD_ANY, tpe_pkg::FIELD_ANY, 8'd0, 8'd255);
		send_request(tpe_pkg::MODE_OBJID, tpe_pkg::OID_INST_MAX, tpe_pkg::OID_TYPE_MAX,
		             8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
	endtask

	task automatic test_context_tags();
		// extended tag number plus four content octets: six octets, exact fit
		send_request(tpe_pkg::MODE_CTX_UNS, 32'hFFFF_FFFF, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd15, 8'd6);
		send_request(tpe_pkg::MODE_CTX_BOOL, 32'd1, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd14, 8'd255);
		send_request(tpe_pkg::MODE_OPEN, 32'd0, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_CLOSE, 32'd0, 16'd0, 8'd0, 8'd0, 8'd0,
		             tpe_pkg::TAG_MAX_NUM, 8'd255);
		send_request(tpe_pkg::MODE_CTX_UNS, 32'd5, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd255, 8'd255);
	endtask

	task automatic test_argument_errors();
		send_request(4'd15, 32'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
		send_request(tpe_pkg::MODE_DATE, 32'd0, 16'd1899, 8'd1, 8'd1, 8'd1,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_TIME, 32'd0, 16'd256, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_OBJID, 32'd0, 16'h0400, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_OBJID, 32'h0040_0000, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd255);
		send_request(tpe_pkg::MODE_REAL, 32'd0, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd4);
		send_request(tpe_pkg::MODE_NULL, 32'd0, 16'd0, 8'd0, 8'd0, 8'd0,
		             8'd0, 8'd0);
	endtask

	// mostly well-formed requests with random content, some noise mixed in
	task automatic test_random_requests(input int count, input bit idling);
		logic [3:0]  mode;
		logic [31:0] v;
		logic [15:0] fa;
		logic [7:0]  fb, fc, fd, ctag, room;
		bit          clean;

		gaps_on = idling;
		stalls_on = idling;
		repeat (count) begin
			mode = ($urandom_range(0, 99) < 4) ? 4'($urandom_range(13, 15))
			                                   : 4'($urandom_range(0, 12));
			clean = $urandom_range(0, 99) < 85;
			v = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 1)) v = ~v;
			fa = 16'($urandom);
			fb = 8'($urandom);
			fc = 8'($urandom);
			fd = 8'($urandom);
			ctag = 8'($urandom);
			room = 8'($urandom);
			if (clean) begin
				room = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 7)) : 8'd255;
				case (mode)
					tpe_pkg::MODE_DATE: begin
						fa = ($urandom_range(0, 9) == 0) ? tpe_pkg::YEAR_ANY
						     : tpe_pkg::YEAR_BASE + 16'($urandom_range(0, 254));
						fb = pick_field(1, 14);
						fc = pick_field(1, 34);
						fd = pick_field(1, 7);
					end
					tpe_pkg::MODE_TIME: begin
						fa = 16'(pick_field(0, 23));
						fb = pick_field(0, 59);
						fc = pick_field(0, 59);
						fd = pick_field(0, 99);
					end
					tpe_pkg::MODE_OBJID: begin
						fa = 16'($urandom_range(0, 1023));
						v = v & tpe_pkg::OID_INST_MAX;
					end
					default: ctag = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15))
					                                            : 8'($urandom_range(0, 254));
				endcase
			end
			send_request(mode, v, fa, fb, fc, fd, ctag, room);
		end
	endtask

	// receiver holds off while requests keep coming, so the queue fills
	task automatic test_output_stall();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		hold_cycles_left = 200;
		for (int i = 0; i < 16; i++)
			send_request(tpe_pkg::MODE_CTX_UNS, 32'h8000_0000 >> i, 16'd0, 8'd0, 8'd0,
			             8'd0, 8'(i * 16), 8'd255);
	endtask

	// output side: random or held-off ready
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles_left > 0) begin
				m_tready <= 1'b0;
				hold_cycles_left--;
			end else if (stalls_on) begin
				m_tready <= ($urandom_range(0, 99) >= GAP_PCT);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// each octet taken at the next rising edge is compared with the oldest expected one
	initial begin
		enc_octet_t e;
		forever begin
			@(negedge clk);
			if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
				if (expected_octets.size() == 0) begin
					$error("unexpected octet %02h last %b error %b", m_tdata, m_tlast, m_tuser);
					fail_count++;
				end else begin
					e = expected_octets.pop_front();
					octets_checked++;
					if (e.err) error_results++;
					if (m_tdata !== e.octet) begin
						$error("octet: expected %02h, got %02h", e.octet, m_tdata);
						fail_count++;
					end
					if (m_tlast !== e.last) begin
						$error("last: expected %b, got %b", e.last, m_tlast);
						fail_count++;
					end
					if (m_tuser !== e.err) begin
						$error("error: expected %b, got %b", e.err, m_tuser);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		#2_500_000;
		$display("timeout with %0d octets outstanding", expected_octets.size());
		$display("** tagged_primitive_encoder_top: FAILED **");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		hold_cycles_left = 0;
		fail_count = 0;
		requests_sent = 0;
		octets_checked = 0;
		error_results = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_integer_lengths();
		test_fixed_modes();
		test_context_tags();
		test_argument_errors();
		test_random_requests(130, 1'b1);
		test_random_requests(90, 1'b0);
		test_output_stall();
		test_random_requests(166, 1'b1);

		s_tvalid <= 1'b0;
		wait_drained();
		if (expected_octets.size() != 0) begin
			$error("%0d expected octets never arrived", expected_octets.size());
			fail_count++;
		end
		$display("%0d requests over all thirteen modes and invalid ones, %0d octets checked,",
		         requests_sent, octets_checked);
		$display("%0d error results, random gaps on both sides and one long output hold-off",
		         error_results);
		if (fail_count == 0) begin
			$display("** tagged_primitive_encoder_top: PASSED **");
		end else begin
			$display("** tagged_primitive_encoder_top: FAILED **");
		end
		$finish;
	end

endmodule
